// ----- rtl/vfao_pkg.sv -----
// shared types, constants and lookup tables for the voxel face quad emitter
`timescale 1ns / 1ps

package vfao_pkg;

    localparam int CHUNK_SIDE_DEFAULT  = 16;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam int COORD_W   = 4;
    localparam int POS_W     = 5;
    localparam int DIR_W     = 3;
    localparam int TEX_W     = 8;
    localparam int OCC_W     = 8;
    localparam int AO_W      = 2;
    localparam int WORD_W    = 32;
    localparam int COUNT_W   = 17;
    localparam int NUM_VERTS = 4;
    localparam int NUM_IDX   = 6;

    // valid face direction codes
    localparam logic [DIR_W-1:0] DIR_TOP    = 3'd0;
    localparam logic [DIR_W-1:0] DIR_BOTTOM = 3'd1;
    localparam logic [DIR_W-1:0] DIR_FRONT  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_BACK   = 3'd3;
    localparam logic [DIR_W-1:0] DIR_LEFT   = 3'd4;
    localparam logic [DIR_W-1:0] DIR_RIGHT  = 3'd5;

    localparam logic [COUNT_W-1:0] VERTS_PER_QUAD = 17'd4;

    typedef struct packed {
        logic dx;
        logic dy;
        logic dz;
        logic u;
        logic v;
    } corner_t;

    // one classified face waiting for vertex assembly
    typedef struct packed {
        logic [COORD_W-1:0]             cx;
        logic [COORD_W-1:0]             cy;
        logic [COORD_W-1:0]             cz;
        logic [DIR_W-1:0]               dir;
        logic [TEX_W-1:0]               tex;
        logic [NUM_VERTS-1:0][AO_W-1:0] ao;
        logic                           normal;
        logic [COUNT_W-1:0]             base;
    } face_t;

    function automatic corner_t corner_of(input logic [DIR_W-1:0] dir,
                                          input logic [1:0] k);
        corner_t c;
        c = '0;
        unique case (dir)
            DIR_TOP:
                case (k)
                    2'd0: c = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
                    2'd1: c = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
                    2'd2: c = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
                    default: c = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
                endcase
            DIR_BOTTOM:
                case (k)
                    2'd0: c = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
                    2'd1: c = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
                    2'd2: c = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
                    default: c = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
                endcase
            DIR_FRONT:
                case (k)
                    2'd0: c = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
                    2'd1: c = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
                    2'd2: c = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
                    default: c = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
                endcase
            DIR_BACK:
                case (k)
                    2'd0: c = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
                    2'd1: c = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
                    2'd2: c = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
                    default: c = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
                endcase
            DIR_LEFT:
                case (k)
                    2'd0: c = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
                    2'd1: c = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
                    2'd2: c = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
                    default: c = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
                endcase
            DIR_RIGHT:
                case (k)
                    2'd0: c = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
                    2'd1: c = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
                    2'd2: c = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
                    default: c = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
                endcase
            default: c = '0;
        endcase
        return c;
    endfunction

    // triangle index table: three winding patterns cover all directions
    function automatic logic [1:0] index_of(input logic [DIR_W-1:0] dir,
                                            input logic [2:0] sel);
        logic [1:0] r;
        r = 2'd0;
        unique case (dir)
            DIR_BOTTOM, DIR_BACK:
                case (sel)
                    3'd1: r = 2'd2;
                    3'd2: r = 2'd1;
                    3'd4: r = 2'd3;
                    3'd5: r = 2'd2;
                    default: r = 2'd0;
                endcase
            DIR_LEFT:
                case (sel)
                    3'd1: r = 2'd2;
                    3'd2: r = 2'd3;
                    3'd4: r = 2'd1;
                    3'd5: r = 2'd2;
                    default: r = 2'd0;
                endcase
            default:
                case (sel)
                    3'd1: r = 2'd1;
                    3'd2: r = 2'd2;
                    3'd4: r = 2'd2;
                    3'd5: r = 2'd3;
                    default: r = 2'd0;
                endcase
        endcase
        return r;
    endfunction

    // flipped quad swaps second and third index of each triangle
    function automatic logic [2:0] flip_sel(input logic [2:0] k);
        logic [2:0] r;
        r = k;
        case (k)
            3'd1: r = 3'd2;
            3'd2: r = 3'd1;
            3'd4: r = 3'd5;
            3'd5: r = 3'd4;
            default: r = k;
        endcase
        return r;
    endfunction

    function automatic logic [AO_W-1:0] ao_level(input logic s1, input logic s2,
                                                 input logic c);
        logic [AO_W-1:0] r;
        if (s1 && s2)
            r = 2'd0;
        else
            r = 2'd3 - ({1'b0, s1} + {1'b0, s2} + {1'b0, c});
        return r;
    endfunction

endpackage

// ----- rtl/vfao_front.sv -----
// front end: accepts faces, culls hidden ones, computes occlusion and index base
`timescale 1ns / 1ps

module vfao_front #(
    parameter int CHUNK_SIDE = vfao_pkg::CHUNK_SIDE_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            chunk_start,
    input  logic [vfao_pkg::COORD_W-1:0]    cell_x,
    input  logic [vfao_pkg::COORD_W-1:0]    cell_y,
    input  logic [vfao_pkg::COORD_W-1:0]    cell_z,
    input  logic [vfao_pkg::DIR_W-1:0]      face_dir,
    input  logic [vfao_pkg::TEX_W-1:0]      texture,
    input  logic                            neighbour_open,
    input  logic [vfao_pkg::OCC_W-1:0]      occlusion_bits,
    input  logic                            q_full,
    output logic                            push,
    output vfao_pkg::face_t                 push_face
);
    import vfao_pkg::*;

    localparam logic [COORD_W:0] SIDE = (COORD_W + 1)'(CHUNK_SIDE);

    logic [COUNT_W-1:0] counter_reg;
    logic [COUNT_W-1:0] counter_next;
    logic [COUNT_W-1:0] base;
    logic               accept;
    logic               visible;
    logic               in_chunk;
    logic               lx, hx, ly, hy, lxly, hxly, lxhy, hxhy;
    logic [AO_W:0]      diag_main;
    logic [AO_W:0]      diag_anti;
    logic [NUM_VERTS-1:0][AO_W-1:0] ao;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign in_chunk = ({1'b0, cell_x} < SIDE) && ({1'b0, cell_y} < SIDE) &&
                      ({1'b0, cell_z} < SIDE);
    assign visible  = neighbour_open && (face_dir <= DIR_RIGHT) && in_chunk;

    assign {hxhy, lxhy, hxly, lxly, hy, ly, hx, lx} = occlusion_bits;

    assign ao[0] = ao_level(lx, ly, lxly);
    assign ao[1] = ao_level(hx, ly, hxly);
    assign ao[2] = ao_level(hx, hy, hxhy);
    assign ao[3] = ao_level(lx, hy, lxhy);

    assign diag_main = {1'b0, ao[0]} + {1'b0, ao[2]};
    assign diag_anti = {1'b0, ao[3]} + {1'b0, ao[1]};

    // chunk start clears even for a culled face
    assign base = chunk_start ? '0 : counter_reg;

    always_comb
    begin
        counter_next = counter_reg;
        if (accept)
            counter_next = visible ? base + VERTS_PER_QUAD : base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            counter_reg <= '0;
        else
            counter_reg <= counter_next;
    end

    assign push = accept && visible;

    always_comb
    begin
        push_face.cx     = cell_x;
        push_face.cy     = cell_y;
        push_face.cz     = cell_z;
        push_face.dir    = face_dir;
        push_face.tex    = texture;
        push_face.ao     = ao;
        push_face.normal = diag_main > diag_anti;
        push_face.base   = base;
    end

endmodule

// ----- rtl/vfao_queue.sv -----
// small fifo of classified faces between front and back end
`timescale 1ns / 1ps

module vfao_queue #(
    parameter int QUEUE_DEPTH = vfao_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  vfao_pkg::face_t push_face,
    output logic            full,
    input  logic            pop,
    output logic            q_valid,
    output vfao_pkg::face_t q_face
);
    import vfao_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

    face_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_pop;

    assign full    = (count_reg == FULL_COUNT);
    assign q_valid = (count_reg != '0);
    assign q_face  = entry_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_face;
    end

endmodule

// ----- rtl/vfao_back.sv -----
// back end: packs vertex words and triangle indices into the output register
`timescale 1ns / 1ps

module vfao_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  vfao_pkg::face_t                q_face,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [vfao_pkg::WORD_W-1:0]    vertex_a,
    output logic [vfao_pkg::WORD_W-1:0]    vertex_b,
    output logic [vfao_pkg::WORD_W-1:0]    vertex_c,
    output logic [vfao_pkg::WORD_W-1:0]    vertex_d,
    output logic [vfao_pkg::COUNT_W-1:0]   index_0,
    output logic [vfao_pkg::COUNT_W-1:0]   index_1,
    output logic [vfao_pkg::COUNT_W-1:0]   index_2,
    output logic [vfao_pkg::COUNT_W-1:0]   index_3,
    output logic [vfao_pkg::COUNT_W-1:0]   index_4,
    output logic [vfao_pkg::COUNT_W-1:0]   index_5
);
    import vfao_pkg::*;

    logic                                 valid_reg;
    logic [NUM_VERTS-1:0][WORD_W-1:0]     word;
    logic [NUM_VERTS-1:0][WORD_W-1:0]     vert_next;
    logic [NUM_VERTS-1:0][WORD_W-1:0]     vert_reg;
    logic [NUM_IDX-1:0][COUNT_W-1:0]      idx_next;
    logic [NUM_IDX-1:0][COUNT_W-1:0]      idx_reg;

    assign pop = q_valid && (!valid_reg || out_ready);

    always_comb
    begin
        corner_t c;
        for (int k = 0; k < NUM_VERTS; k++)
        begin
            c = corner_of(q_face.dir, k[1:0]);
            word[k] = {1'b0, 1'b0, q_face.ao[k], q_face.tex, q_face.dir, c.v, c.u,
                       {1'b0, q_face.cz} + {4'd0, c.dz},
                       {1'b0, q_face.cy} + {4'd0, c.dy},
                       {1'b0, q_face.cx} + {4'd0, c.dx}};
        end
        // flipped quad reverses vertex order
        for (int k = 0; k < NUM_VERTS; k++)
            vert_next[k] = q_face.normal ? word[k] : word[NUM_VERTS - 1 - k];
    end

    always_comb
    begin
        logic [2:0] sel;
        for (int k = 0; k < NUM_IDX; k++)
        begin
            sel = q_face.normal ? k[2:0] : flip_sel(k[2:0]);
            idx_next[k] = q_face.base + {15'd0, index_of(q_face.dir, sel)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            vert_reg <= vert_next;
            idx_reg  <= idx_next;
        end
    end

    assign out_valid = valid_reg;
    assign vertex_a  = vert_reg[0];
    assign vertex_b  = vert_reg[1];
    assign vertex_c  = vert_reg[2];
    assign vertex_d  = vert_reg[3];
    assign index_0   = idx_reg[0];
    assign index_1   = idx_reg[1];
    assign index_2   = idx_reg[2];
    assign index_3   = idx_reg[3];
    assign index_4   = idx_reg[4];
    assign index_5   = idx_reg[5];

endmodule

// ----- rtl/voxel_face_ao_quad_emitter_top.sv -----
// top level of the voxel face emitter with per-vertex ambient occlusion
//
//   channel   handshake              payload
//   in        in_valid / in_ready    chunk_start, cell_x/y/z, face_dir, texture,
//                                    neighbour_open, occlusion_bits
//   out       out_valid / out_ready  vertex_a..vertex_d, index_0..index_5
//
// one face per cycle sustained while out_ready stays high; a visible face
// goes from the front, which culls and counts in the same cycle it is taken,
// through the queue register and then the output register to out
// hidden faces take one beat on in and produce nothing on out
// in_ready drops only when the face queue is full; out stalls fill the queue
// rst_n clears the vertex counter, the queue and the output valid
`timescale 1ns / 1ps

module voxel_face_ao_quad_emitter_top #(
    parameter int CHUNK_SIDE  = vfao_pkg::CHUNK_SIDE_DEFAULT,
    parameter int QUEUE_DEPTH = vfao_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           chunk_start,
    input  logic [vfao_pkg::COORD_W-1:0]   cell_x,
    input  logic [vfao_pkg::COORD_W-1:0]   cell_y,
    input  logic [vfao_pkg::COORD_W-1:0]   cell_z,
    input  logic [vfao_pkg::DIR_W-1:0]     face_dir,
    input  logic [vfao_pkg::TEX_W-1:0]     texture,
    input  logic                           neighbour_open,
    input  logic [vfao_pkg::OCC_W-1:0]     occlusion_bits,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [vfao_pkg::WORD_W-1:0]    vertex_a,
    output logic [vfao_pkg::WORD_W-1:0]    vertex_b,
    output logic [vfao_pkg::WORD_W-1:0]    vertex_c,
    output logic [vfao_pkg::WORD_W-1:0]    vertex_d,
    output logic [vfao_pkg::COUNT_W-1:0]   index_0,
    output logic [vfao_pkg::COUNT_W-1:0]   index_1,
    output logic [vfao_pkg::COUNT_W-1:0]   index_2,
    output logic [vfao_pkg::COUNT_W-1:0]   index_3,
    output logic [vfao_pkg::COUNT_W-1:0]   index_4,
    output logic [vfao_pkg::COUNT_W-1:0]   index_5
);
    import vfao_pkg::*;

    logic  q_full;
    logic  push;
    logic  pop;
    logic  q_valid;
    face_t push_face;
    face_t q_face;

    vfao_front #(
        .CHUNK_SIDE (CHUNK_SIDE)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .chunk_start    (chunk_start),
        .cell_x         (cell_x),
        .cell_y         (cell_y),
        .cell_z         (cell_z),
        .face_dir       (face_dir),
        .texture        (texture),
        .neighbour_open (neighbour_open),
        .occlusion_bits (occlusion_bits),
        .q_full         (q_full),
        .push           (push),
        .push_face      (push_face)
    );

    vfao_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_face (push_face),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_face    (q_face)
    );

    vfao_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_face    (q_face),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .vertex_a  (vertex_a),
        .vertex_b  (vertex_b),
        .vertex_c  (vertex_c),
        .vertex_d  (vertex_d),
        .index_0   (index_0),
        .index_1   (index_1),
        .index_2   (index_2),
        .index_3   (index_3),
        .index_4   (index_4),
        .index_5   (index_5)
    );

endmodule

// ----- verif/voxel_face_ao_quad_emitter_top_tb.sv -----
// self-checking testbench for the voxel face quad emitter, with a scoreboard class
`timescale 1ns / 1ps

module voxel_face_ao_quad_emitter_top_tb;
    import vfao_pkg::*;

    typedef struct packed {
        logic               chunk_start;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] cz;
        logic [DIR_W-1:0]   dir;
        logic [TEX_W-1:0]   tex;
        logic               open;
        logic [OCC_W-1:0]   occ;
    } face_in_t;

    typedef struct packed {
        logic [NUM_VERTS-1:0][WORD_W-1:0] vert;
        logic [NUM_IDX-1:0][COUNT_W-1:0]  idx;
    } quad_t;

    // direction codes with no face behind them
    localparam logic [DIR_W-1:0] DIR_SPARE_LO = 3'd6;
    localparam logic [DIR_W-1:0] DIR_SPARE_HI = 3'd7;

    // corner offsets per direction, packed as {dx, dy, dz, u, v}
    localparam logic [4:0] CORNER_OFS [6][4] = '{
        '{5'b01000, 5'b11010, 5'b11111, 5'b01101},
        '{5'b00000, 5'b10010, 5'b10111, 5'b00101},
        '{5'b00000, 5'b10010, 5'b11011, 5'b01001},
        '{5'b00100, 5'b10110, 5'b11111, 5'b01101},
        '{5'b00000, 5'b01001, 5'b01111, 5'b00110},
        '{5'b10000, 5'b10110, 5'b11111, 5'b11001}
    };

    localparam logic [1:0] WINDING [6][6] = '{
        '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3},
        '{2'd0, 2'd2, 2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3},
        '{2'd0, 2'd2, 2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd0, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2},
        '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3}
    };

    // flipped diagonal swaps the last two indices of each triangle
    localparam int TRI_SWAP [6] = '{0, 2, 1, 3, 5, 4};

    localparam logic [OCC_W-1:0] OCC_MIX [6] = '{8'h06, 8'hFF, 8'h09, 8'hF0, 8'h0F, 8'h55};

    class quad_scoreboard;
        logic [COUNT_W-1:0] vert_count;
        quad_t              quads_due[$];
        int                 faces_taken;
        int                 quads_checked;
        int                 hidden_faces;
        int                 flipped_quads;
        int                 counter_wraps;
        int                 mismatches;

        function new();
            vert_count    = '0;
            faces_taken   = 0;
            quads_checked = 0;
            hidden_faces  = 0;
            flipped_quads = 0;
            counter_wraps = 0;
            mismatches    = 0;
        endfunction

        static function logic [1:0] corner_shade(logic side_a, logic side_b, logic diag);
            if (side_a && side_b)
                return 2'd0;
            return 2'd3 - {1'b0, side_a} - {1'b0, side_b} - {1'b0, diag};
        endfunction

        function void note_face(face_in_t f);
            logic [1:0]        shade [4];
            logic [WORD_W-1:0] word [4];
            logic [4:0]        ofs;
            quad_t             q;
            bit                normal;
            int                k;
            faces_taken++;
            if (f.chunk_start)
                vert_count = '0;
            if (!f.open || f.dir > DIR_RIGHT || f.cx >= CHUNK_SIDE_DEFAULT ||
                f.cy >= CHUNK_SIDE_DEFAULT || f.cz >= CHUNK_SIDE_DEFAULT)
            begin
                hidden_faces++;
                return;
            end
            shade[0] = corner_shade(f.occ[0], f.occ[2], f.occ[4]);
            shade[1] = corner_shade(f.occ[1], f.occ[2], f.occ[5]);
            shade[2] = corner_shade(f.occ[1], f.occ[3], f.occ[7]);
            shade[3] = corner_shade(f.occ[0], f.occ[3], f.occ[6]);
            for (k = 0; k < 4; k++)
            begin
                ofs = CORNER_OFS[f.dir][k];
                word[k] = {1'b0, 1'b0, shade[k], f.tex, f.dir, ofs[0], ofs[1],
                           {1'b0, f.cz} + ofs[2], {1'b0, f.cy} + ofs[3],
                           {1'b0, f.cx} + ofs[4]};
            end
            normal = (int'(shade[0]) + int'(shade[2])) > (int'(shade[1]) + int'(shade[3]));
            if (!normal)
                flipped_quads++;
            for (k = 0; k < 4; k++)
                q.vert[k] = word[normal ? k : 3 - k];
            for (k = 0; k < 6; k++)
                q.idx[k] = vert_count + WINDING[f.dir][normal ? k : TRI_SWAP[k]];
            vert_count = vert_count + VERTS_PER_QUAD;
            if (vert_count == '0)
                counter_wraps++;
            quads_due.push_back(q);
        endfunction

        function void check_quad(quad_t got);
            quad_t want;
            int    k;
            if (quads_due.size() == 0)
            begin
                $display("%0t: quad with no face waiting, got %h", $time, got);
                mismatches++;
                return;
            end
            want = quads_due.pop_front();
            quads_checked++;
            for (k = 0; k < 4; k++)
                if (got.vert[k] !== want.vert[k])
                begin
                    $display("%0t: vertex %0d expected %h got %h",
                             $time, k, want.vert[k], got.vert[k]);
                    mismatches++;
                end
            for (k = 0; k < 6; k++)
                if (got.idx[k] !== want.idx[k])
                begin
                    $display("%0t: index %0d expected %h got %h",
                             $time, k, want.idx[k], got.idx[k]);
                    mismatches++;
                end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               chunk_start = 1'b0;
    logic [COORD_W-1:0] cell_x = '0;
    logic [COORD_W-1:0] cell_y = '0;
    logic [COORD_W-1:0] cell_z = '0;
    logic [DIR_W-1:0]   face_dir = '0;
    logic [TEX_W-1:0]   texture = '0;
    logic               neighbour_open = 1'b0;
    logic [OCC_W-1:0]   occlusion_bits = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [WORD_W-1:0]  vertex_a, vertex_b, vertex_c, vertex_d;
    logic [COUNT_W-1:0] index_0, index_1, index_2, index_3, index_4, index_5;

    logic               steady = 1'b0;
    face_in_t           taken;
    quad_t              shown;
    quad_scoreboard     board = new();

    voxel_face_ao_quad_emitter_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .chunk_start    (chunk_start),
        .cell_x         (cell_x),
        .cell_y         (cell_y),
        .cell_z         (cell_z),
        .face_dir       (face_dir),
        .texture        (texture),
        .neighbour_open (neighbour_open),
        .occlusion_bits (occlusion_bits),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .vertex_a       (vertex_a),
        .vertex_b       (vertex_b),
        .vertex_c       (vertex_c),
        .vertex_d       (vertex_d),
        .index_0        (index_0),
        .index_1        (index_1),
        .index_2        (index_2),
        .index_3        (index_3),
        .index_4        (index_4),
        .index_5        (index_5)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_ready <= steady || ($urandom_range(99) >= 6);
    end

    // beat monitors: values read here are the ones before this edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            taken.chunk_start = chunk_start;
            taken.cx          = cell_x;
            taken.cy          = cell_y;
            taken.cz          = cell_z;
            taken.dir         = face_dir;
            taken.tex         = texture;
            taken.open        = neighbour_open;
            taken.occ         = occlusion_bits;
            board.note_face(taken);
        end
        if (rst_n && out_valid && out_ready)
        begin
            shown.vert = {vertex_d, vertex_c, vertex_b, vertex_a};
            shown.idx  = {index_5, index_4, index_3, index_2, index_1, index_0};
            board.check_quad(shown);
        end
    end

    task automatic send_face(input face_in_t f);
        while (!steady && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        chunk_start    <= f.chunk_start;
        cell_x         <= f.cx;
        cell_y         <= f.cy;
        cell_z         <= f.cz;
        face_dir       <= f.dir;
        texture        <= f.tex;
        neighbour_open <= f.open;
        occlusion_bits <= f.occ;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    function automatic face_in_t random_face(input bit visible_only);
        face_in_t f;
        f.chunk_start = ($urandom_range(99) < 3);
        f.cx          = COORD_W'($urandom_range(15));
        f.cy          = COORD_W'($urandom_range(15));
        f.cz          = COORD_W'($urandom_range(15));
        f.dir         = ($urandom_range(9) == 0) ? DIR_W'($urandom_range(7, 6))
                                                 : DIR_W'($urandom_range(5));
        f.tex         = TEX_W'($urandom_range(255));
        f.open        = ($urandom_range(99) < 85);
        f.occ         = OCC_W'($urandom_range(255));
        if (visible_only)
        begin
            f.chunk_start = 1'b0;
            f.open        = 1'b1;
            f.dir         = DIR_W'($urandom_range(5));
        end
        return f;
    endfunction

    initial
    begin
        int i;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: corners of the cell range, every direction, both diagonals
        send_face(face_in_t'{1'b1, 4'd0, 4'd0, 4'd0, DIR_TOP, 8'd0, 1'b1, 8'h00});
        for (i = 0; i < 6; i++)
            send_face(face_in_t'{1'b0, 4'd15, 4'd15, 4'd15, DIR_W'(i), 8'd255, 1'b1,
                                 OCC_MIX[i]});
        // hidden face still clears the counter
        send_face(face_in_t'{1'b1, 4'd3, 4'd5, 4'd7, DIR_FRONT, 8'h5A, 1'b0, 8'h06});
        send_face(face_in_t'{1'b0, 4'd15, 4'd0, 4'd15, DIR_LEFT, 8'hAA, 1'b1, 8'h06});
        send_face(face_in_t'{1'b0, 4'd1, 4'd1, 4'd1, DIR_SPARE_LO, 8'h11, 1'b1, 8'h00});
        send_face(face_in_t'{1'b1, 4'd2, 4'd2, 4'd2, DIR_SPARE_HI, 8'h22, 1'b1, 8'hFF});
        send_face(face_in_t'{1'b0, 4'd0, 4'd15, 4'd0, DIR_RIGHT, 8'h55, 1'b1, 8'h09});
        send_face(face_in_t'{1'b0, 4'd9, 4'd6, 4'd10, DIR_BACK, 8'h80, 1'b0, 8'hFF});
        send_face(face_in_t'{1'b0, 4'd8, 4'd4, 4'd12, DIR_BOTTOM, 8'h01, 1'b1, 8'hAA});

        for (i = 0; i < 500; i++)
            send_face(random_face(1'b0));

        // full-rate stretch with no idling on either side
        steady <= 1'b1;
        send_face(face_in_t'{1'b1, 4'd4, 4'd4, 4'd4, DIR_TOP, 8'h33, 1'b1, 8'h00});
        for (i = 0; i < 1000; i++)
            send_face(random_face(1'b1));
        steady <= 1'b0;

        for (i = 0; i < 500; i++)
            send_face(random_face(1'b0));
        in_valid <= 1'b0;

        while (board.quads_due.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("faces accepted %0d, quads checked %0d, hidden %0d",
                 board.faces_taken, board.quads_checked, board.hidden_faces);
        $display("flipped diagonals %0d, vertex counter wraps %0d, mismatches %0d",
                 board.flipped_quads, board.counter_wraps, board.mismatches);
        if (board.mismatches == 0)
            $display("voxel_face_ao_quad_emitter_top_tb: PASS");
        else
            $display("voxel_face_ao_quad_emitter_top_tb: FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d quads outstanding", board.quads_due.size());
        $display("voxel_face_ao_quad_emitter_top_tb: FAIL");
        $finish;
    end

endmodule
